[src/ffea_pkg.sv]
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared widths, codes and types for the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int MEM_SIZE    = 1024;
  localparam int MAX_EXTENTS = 16;
  localparam int AW          = $clog2(MEM_SIZE);
  localparam int SW          = AW + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_SIZE - 1);
  localparam logic [SW:0]   MEM_LIMIT = (SW+1)'(MEM_SIZE);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_SHRINK = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_JBOTH  = 3'd3;
  localparam logic [2:0] OP_JPREV  = 3'd4;
  localparam logic [2:0] OP_JNEXT  = 3'd5;
  localparam logic [2:0] OP_INSERT = 3'd6;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] first;
    logic [AW-1:0] last;
  } ext_t;

  typedef struct packed {
    logic [2:0]    op;
    logic          shift;
    logic          clear;
    logic          func;
    logic [SW-1:0] size;
    logic [AW-1:0] addr;
    logic [AW-1:0] end_addr;
  } ctl_t;

  typedef struct packed {
    logic          sel;
    logic          exact;
    logic          nofit;
    logic          bad;
    logic          jp;
    logic          jn;
    logic [AW-1:0] first;
  } cell_stat_t;

  localparam ext_t EXT_EMPTY = '{valid: 1'b0, first: '0, last: '0};

endpackage

[src/ffea_cell.sv]
// ----------------------------------------------------------------------------
// ffea_cell
// One free-extent slot: holds an extent, passes the search token right and
// shifts its extent left or right on remove and insert.
// ----------------------------------------------------------------------------
module ffea_cell import ffea_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head,
  input  ctl_t       ctl,
  input  ext_t       left,
  input  logic       left_tok,
  input  logic       ge_in,
  input  ext_t       right,
  input  logic       right_tok,
  output ext_t       ext,
  output logic       tok,
  output logic       ge_out,
  output cell_stat_t stat
);

  logic [SW-1:0] len;
  logic          stop;

  assign len    = {1'b0, ext.last} - {1'b0, ext.first} + SW'(1);
  assign ge_out = ge_in | tok;

  always_comb begin
    if (ctl.func == FUNC_RELEASE) begin
      stop = !ext.valid || (ext.first > ctl.addr);
    end else begin
      stop = !ext.valid || (len >= ctl.size);
    end
    stat.sel   = tok & stop;
    stat.exact = ext.valid && (len == ctl.size);
    stat.nofit = !ext.valid;
    stat.bad   = (left.valid && (left.last >= ctl.addr)) ||
                 (ext.valid && (ext.first <= ctl.end_addr));
    stat.jp    = left.valid && (({1'b0, left.last} + SW'(1)) == {1'b0, ctl.addr});
    stat.jn    = ext.valid && (({1'b0, ctl.end_addr} + SW'(1)) == {1'b0, ext.first});
    stat.first = ext.first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.clear) begin
      tok <= 1'b0;
    end else if (ctl.shift) begin
      tok <= left_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext.valid <= head;
      ext.first <= '0;
      ext.last  <= LAST_ADDR;
    end else begin
      case (ctl.op)
        OP_SHRINK: begin
          if (tok) ext.first <= ext.first + ctl.size[AW-1:0];
        end
        OP_REMOVE: begin
          if (ge_out) ext <= right;
        end
        OP_JBOTH: begin
          if (right_tok) ext.last <= right.last;
          else if (ge_out) ext <= right;
        end
        OP_JPREV: begin
          if (right_tok) ext.last <= ctl.end_addr;
        end
        OP_JNEXT: begin
          if (tok) ext.first <= ctl.addr;
        end
        OP_INSERT: begin
          if (tok) begin
            ext.valid <= 1'b1;
            ext.first <= ctl.addr;
            ext.last  <= ctl.end_addr;
          end else if (ge_out) begin
            ext <= left;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/first_fit_extent_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// Address-ordered free-extent table in a row of cells; first-fit allocate and
// merging release.
//
//   channel  signals                                  direction
//   in       in_valid in_ready func block_size         input item
//            block_address
//   out      out_valid out_ready granted               result item
//            start_address status
//
// The search token steps one cell a cycle until it finds the first fitting
// extent (or insertion point), then the whole row updates together. A bad
// size or range goes straight to the result without a search.
// One item is in flight at a time; in_ready is low until its result is taken.
// Reset leaves one extent covering all of memory.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator import ffea_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          func,
  input  logic [10:0]   block_size,
  input  logic [AW-1:0] block_address,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          granted,
  output logic [AW-1:0] start_address,
  output logic [1:0]    status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    state, state_next;
  logic          func_r;
  logic [SW-1:0] size_r;
  logic [AW-1:0] addr_r, end_r;
  logic          offend;

  ctl_t                   ctl;
  ext_t                   ext  [MAX_EXTENTS];
  cell_stat_t             stat [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] tok;
  logic [MAX_EXTENTS:0]   ge;

  logic       accept, bad_in, hit, decide;
  cell_stat_t pick;
  logic [2:0] op_d;
  logic [1:0] st_d;
  logic [SW:0] rel_top;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rel_top  = {1'b0, block_size} + {2'b0, block_address};

  always_comb begin
    if (func == FUNC_RELEASE) begin
      bad_in = (block_size == '0) || (rel_top > MEM_LIMIT);
    end else begin
      bad_in = (block_size == '0) || ({1'b0, block_size} > MEM_LIMIT);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (stat[i].sel) pick = pick | stat[i];
    end
  end

  assign hit    = |tok & pick.sel;
  assign decide = (state == S_SCAN) && (hit || offend);

  always_comb begin
    op_d = OP_NONE;
    st_d = ST_OK;
    if (offend) begin
      if (func_r == FUNC_ALLOC) begin
        st_d = ST_NOFIT;
      end else if (ext[MAX_EXTENTS-1].last >= addr_r) begin
        st_d = ST_BAD;
      end else if (({1'b0, ext[MAX_EXTENTS-1].last} + SW'(1)) == {1'b0, addr_r}) begin
        op_d = OP_JPREV;
      end else begin
        st_d = ST_FULL;
      end
    end else if (func_r == FUNC_ALLOC) begin
      if (pick.nofit) st_d = ST_NOFIT;
      else if (pick.exact) op_d = OP_REMOVE;
      else op_d = OP_SHRINK;
    end else begin
      if (pick.bad) st_d = ST_BAD;
      else if (pick.jp && pick.jn) op_d = OP_JBOTH;
      else if (pick.jp) op_d = OP_JPREV;
      else if (pick.jn) op_d = OP_JNEXT;
      else if (ext[MAX_EXTENTS-1].valid) st_d = ST_FULL;
      else op_d = OP_INSERT;
    end
  end

  always_comb begin
    ctl.op       = decide ? op_d : OP_NONE;
    ctl.shift    = accept || ((state == S_SCAN) && !hit && !offend);
    ctl.clear    = decide;
    ctl.func     = func_r;
    ctl.size     = size_r;
    ctl.addr     = addr_r;
    ctl.end_addr = end_r;
  end

  assign ge[0] = 1'b0;

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    ext_t left_d, right_d;
    logic left_tok, right_tok;
    if (i == 0) begin : g_head
      assign left_d   = EXT_EMPTY;
      assign left_tok = accept && !bad_in;
    end else begin : g_body
      assign left_d   = ext[i-1];
      assign left_tok = tok[i-1];
    end
    if (i == MAX_EXTENTS - 1) begin : g_tail
      assign right_d   = EXT_EMPTY;
      assign right_tok = offend;
    end else begin : g_mid
      assign right_d   = ext[i+1];
      assign right_tok = tok[i+1];
    end
    ffea_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .head      (i == 0),
      .ctl       (ctl),
      .left      (left_d),
      .left_tok  (left_tok),
      .ge_in     (ge[i]),
      .right     (right_d),
      .right_tok (right_tok),
      .ext       (ext[i]),
      .tok       (tok[i]),
      .ge_out    (ge[i+1]),
      .stat      (stat[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = bad_in ? S_OUT : S_SCAN;
      S_SCAN: if (decide) state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      offend <= 1'b0;
    end else begin
      state <= state_next;
      if (decide || accept) offend <= 1'b0;
      else if (ctl.shift) offend <= tok[MAX_EXTENTS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r        <= func;
      size_r        <= block_size;
      addr_r        <= block_address;
      end_r         <= rel_top[AW-1:0] - AW'(1);
      granted       <= 1'b0;
      start_address <= '0;
      status        <= ST_BAD;
    end else if (decide) begin
      granted       <= (st_d == ST_OK);
      start_address <= ((st_d == ST_OK) && (func_r == FUNC_ALLOC)) ? pick.first : '0;
      status        <= st_d;
    end
  end

  assign out_valid = (state == S_OUT);

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output side active together");
  a_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (granted == (status == ST_OK)))
    else $error("granted disagrees with status");
  a_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok))
    else $error("more than one search token");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (start_address == '0))
    else $error("start address on failed request");

endmodule

[tb/ffea_checker.sv]
// ----------------------------------------------------------------------------
// ffea_checker
// Watches both channels of the first-fit extent allocator, keeps its own free
// extent table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module ffea_checker import ffea_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic          func,
  input  logic [10:0]   block_size,
  input  logic [AW-1:0] block_address,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic          granted,
  input  logic [AW-1:0] start_address,
  input  logic [1:0]    status,
  output int            fail_count,
  output int            pending
);

  typedef struct packed {
    logic          granted;
    logic [AW-1:0] start;
    logic [1:0]    status;
  } answer_t;

  int free_lo [MAX_EXTENTS];
  int free_hi [MAX_EXTENTS];
  int free_n;
  answer_t answers_due[$];

  assign pending = answers_due.size();

  function automatic void drop_extent(int pos);
    for (int k = pos; k + 1 < free_n; k++) begin
      free_lo[k] = free_lo[k+1];
      free_hi[k] = free_hi[k+1];
    end
    free_n--;
  endfunction

  function automatic answer_t predict_answer(logic f, int size, int addr);
    answer_t a;
    int pos;
    int last;
    bit jp;
    bit jn;
    a = '{granted: 1'b0, start: '0, status: ST_NOFIT};
    if (f == FUNC_ALLOC) begin
      if (size == 0 || size > MEM_SIZE) begin
        a.status = ST_BAD;
        return a;
      end
      for (int k = 0; k < free_n; k++) begin
        if (free_hi[k] - free_lo[k] + 1 >= size) begin
          a = '{granted: 1'b1, start: AW'(free_lo[k]), status: ST_OK};
          if (free_hi[k] - free_lo[k] + 1 == size) drop_extent(k);
          else free_lo[k] += size;
          return a;
        end
      end
      return a;
    end
    a.status = ST_BAD;
    if (size == 0 || addr + size > MEM_SIZE) return a;
    last = addr + size - 1;
    pos = 0;
    while (pos < free_n && free_lo[pos] <= addr) pos++;
    if (pos > 0 && free_hi[pos-1] >= addr) return a;
    if (pos < free_n && free_lo[pos] <= last) return a;
    jp = pos > 0 && free_hi[pos-1] + 1 == addr;
    jn = pos < free_n && last + 1 == free_lo[pos];
    if (jp && jn) begin
      free_hi[pos-1] = free_hi[pos];
      drop_extent(pos);
    end else if (jp) begin
      free_hi[pos-1] = last;
    end else if (jn) begin
      free_lo[pos] = addr;
    end else begin
      if (free_n >= MAX_EXTENTS) begin
        a.status = ST_FULL;
        return a;
      end
      for (int k = free_n; k > pos; k--) begin
        free_lo[k] = free_lo[k-1];
        free_hi[k] = free_hi[k-1];
      end
      free_lo[pos] = addr;
      free_hi[pos] = last;
      free_n++;
    end
    a.status = ST_OK;
    a.granted = 1'b1;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      free_n = 1;
      free_lo[0] = 0;
      free_hi[0] = MEM_SIZE - 1;
      fail_count <= 0;
      answers_due.delete();
    end else begin
      if (in_valid && in_ready)
        answers_due.push_back(predict_answer(func, int'(block_size), int'(block_address)));
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result g=%0b a=%0d s=%0d", $time,
                   granted, start_address, status);
          fail_count <= fail_count + 1;
        end else begin
          e = answers_due.pop_front();
          if (e !== {granted, start_address, status}) begin
            $display("%0t: mismatch expected g=%0b a=%0d s=%0d got g=%0b a=%0d s=%0d",
                     $time, e.granted, e.start, e.status, granted, start_address,
                     status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the first-fit extent allocator: directed corner requests, then
// random allocate and release traffic, mostly built from a record of granted
// blocks, with random idling on both channels until a calm final stretch.
// ----------------------------------------------------------------------------
module tb import ffea_pkg::*; ();

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          func = FUNC_ALLOC;
  logic [10:0]   block_size = '0;
  logic [AW-1:0] block_address = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          granted;
  logic [AW-1:0] start_address;
  logic [1:0]    status;
  int            fail_count;
  int            pending;
  int            cycles = 0;
  bit            calm = 1'b0;

  int held_addr[$];
  int held_size[$];

  always #5 clk = ~clk;

  first_fit_extent_allocator DUT (.*);

  ffea_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int idle;
    out_ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        idle = $urandom_range(1, 19);
        repeat (idle) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        idle = $urandom_range(1, 19);
        repeat (idle) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic f, int size, int addr);
    if (!calm && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 19)) @(posedge clk);
    func <= f;
    block_size <= 11'(size);
    block_address <= AW'(addr);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic alloc_tracked(int size);
    int ok;
    send_request(FUNC_ALLOC, size, int'($urandom_range(0, 1023)));
    drain_results();
    ok = (granted === 1'b1);
    if (ok) begin
      held_addr.push_back(int'(start_address));
      held_size.push_back(size);
    end
  endtask

  initial begin
    int k;
    int sz;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send_request(FUNC_ALLOC, 0, 0);
    send_request(FUNC_RELEASE, 0, 5);
    send_request(FUNC_ALLOC, 1025, 0);
    send_request(FUNC_ALLOC, 2047, 1023);
    send_request(FUNC_RELEASE, 1, 1023);
    send_request(FUNC_RELEASE, 2, 1023);
    send_request(FUNC_ALLOC, 1024, 0);
    send_request(FUNC_ALLOC, 1, 0);
    send_request(FUNC_RELEASE, 1024, 0);
    send_request(FUNC_RELEASE, 1024, 0);
    for (k = 0; k < 16; k++) send_request(FUNC_ALLOC, 64, 0);
    send_request(FUNC_ALLOC, 1, 0);
    for (k = 0; k < 8; k++) send_request(FUNC_RELEASE, 64, k * 128);
    send_request(FUNC_RELEASE, 64, 64);
    send_request(FUNC_RELEASE, 64, 128 + 64);
    send_request(FUNC_RELEASE, 2, 0);
    drain_results();
    // table full: free every other unit in a fresh layout
    send_request(FUNC_RELEASE, 1024 - 320, 320);
    drain_results();
    for (k = 0; k < 6; k++) send_request(FUNC_RELEASE, 64, k * 64);
    send_request(FUNC_RELEASE, 1023, 0);
    drain_results();
    for (k = 0; k < 40; k++) alloc_tracked(1);
    for (k = 0; k < 40; k += 2) begin
      send_request(FUNC_RELEASE, 1, held_addr[k]);
    end
    drain_results();
    for (k = 1; k < 40; k += 2) send_request(FUNC_RELEASE, 1, held_addr[k]);
    drain_results();
    held_addr.delete();
    held_size.delete();
    // random traffic
    for (k = 0; k < 480; k++) begin
      if (k == 420) begin
        drain_results();
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1100) :
               $urandom_range(1, 80);
          alloc_tracked(sz);
        end
        4, 5, 6, 7: if (held_addr.size() > 0) begin
          int j;
          j = $urandom_range(0, held_addr.size() - 1);
          send_request(FUNC_RELEASE, held_size[j], held_addr[j]);
          held_addr.delete(j);
          held_size.delete(j);
        end else begin
          alloc_tracked($urandom_range(1, 40));
        end
        default: send_request(1'($urandom_range(0, 1)), int'($urandom_range(0, 2047)),
                              int'($urandom_range(0, 1023)));
      endcase
    end
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
